// ----- src/dbgpio_pkg.sv -----
// Package with the shared types, constants and codes of the dual-bank GPIO pin controller.
`timescale 1ns / 1ps
`default_nettype none
package dbgpio_pkg;

  localparam int BANK_COUNT = 2;
  localparam int BANK_PINS  = 32;
  localparam int PIN_W      = (BANK_PINS > 1) ? $clog2(BANK_PINS) : 1;
  localparam int BANK_W     = 1;
  localparam int WIDTH_W    = 6;
  localparam int FLAT_W     = 6;
  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic [BANK_PINS-1:0] word_t;

  typedef enum logic [2:0] {
    FUNC_SET_VALUE  = 3'd0,
    FUNC_GET_VALUE  = 3'd1,
    FUNC_GET_FUNC   = 3'd2,
    FUNC_MAKE_OUT   = 3'd3,
    FUNC_MAKE_IN    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_PIN  = 2'd1,
    ERR_LOCK = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_WIDTH     = 3'd0,
    CFG_SECOND_WIDTH    = 3'd1,
    CFG_FIRST_FIXED_IN  = 3'd2,
    CFG_FIRST_FIXED_OUT = 3'd3,
    CFG_SECOND_FIXED_IN = 3'd4,
    CFG_SECOND_FIXED_OUT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [FLAT_W-1:0]  pin_offset;
    logic               pin_value;
    logic [FIELD_W-1:0] input_levels;
  } in_item_t;

  typedef struct packed {
    logic               read_bit;
    logic [1:0]         error_code;
    logic [FIELD_W-1:0] bank_data_out;
    logic [FIELD_W-1:0] bank_dir_out;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] first_width;
    logic [WIDTH_W-1:0] second_width;
    logic               first_fixed_in;
    logic               first_fixed_out;
    logic               second_fixed_in;
    logic               second_fixed_out;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
    logic [PIN_W-1:0]  pin;
  } pin_loc_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    word_t             data;
    word_t             dir;
  } bank_wr_t;

endpackage
`default_nettype wire

// ----- src/dbgpio_pin_decode.sv -----
// Splits a flat pin number into bank and pin using the configured bank widths.
`timescale 1ns / 1ps
`default_nettype none
module dbgpio_pin_decode (
  input  wire logic [dbgpio_pkg::FLAT_W-1:0] flat,
  input  wire dbgpio_pkg::cfg_t              cfg,
  output dbgpio_pkg::pin_loc_t               loc
);

  localparam logic [dbgpio_pkg::WIDTH_W-1:0] PinsMax =
    dbgpio_pkg::WIDTH_W'(dbgpio_pkg::BANK_PINS);

  logic [dbgpio_pkg::WIDTH_W-1:0] w0;
  logic [dbgpio_pkg::WIDTH_W-1:0] w1;
  logic [dbgpio_pkg::FLAT_W-1:0]  rel;

  always_comb begin
    w0  = (cfg.first_width > PinsMax) ? PinsMax : cfg.first_width;
    w1  = (cfg.second_width > PinsMax) ? PinsMax : cfg.second_width;
    rel = flat - w0;
    loc = '0;
    if (flat < w0) begin
      loc.valid = 1'b1;
      loc.bank  = '0;
      loc.pin   = dbgpio_pkg::PIN_W'(flat);
    end else if ((dbgpio_pkg::BANK_COUNT >= 2) && (rel < w1)) begin
      loc.valid = 1'b1;
      loc.bank  = dbgpio_pkg::BANK_W'(1);
      loc.pin   = dbgpio_pkg::PIN_W'(rel);
    end
  end

endmodule
`default_nettype wire

// ----- src/dbgpio_bank_file.sv -----
// Data and direction words of every bank, with one read port and one write port.
`timescale 1ns / 1ps
`default_nettype none
module dbgpio_bank_file (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [dbgpio_pkg::BANK_W-1:0]   rd_bank,
  output dbgpio_pkg::word_t                    rd_data,
  output dbgpio_pkg::word_t                    rd_dir,
  input  wire dbgpio_pkg::bank_wr_t            wr
);

  dbgpio_pkg::word_t data_r [dbgpio_pkg::BANK_COUNT];
  dbgpio_pkg::word_t dir_r  [dbgpio_pkg::BANK_COUNT];

  assign rd_data = data_r[rd_bank];
  assign rd_dir  = dir_r[rd_bank];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dbgpio_pkg::BANK_COUNT; i++) begin
        data_r[i] <= '0;
        dir_r[i]  <= '1;
      end
    end else if (wr.en) begin
      data_r[wr.bank] <= wr.data;
      dir_r[wr.bank]  <= wr.dir;
    end
  end

endmodule
`default_nettype wire

// ----- src/dbgpio_pin_op.sv -----
// Executes one pin operation against the addressed bank's words.
`timescale 1ns / 1ps
`default_nettype none
module dbgpio_pin_op (
  input  wire dbgpio_pkg::in_item_t  item,
  input  wire dbgpio_pkg::pin_loc_t  loc,
  input  wire dbgpio_pkg::cfg_t      cfg,
  input  wire dbgpio_pkg::word_t     cur_data,
  input  wire dbgpio_pkg::word_t     cur_dir,
  output dbgpio_pkg::bank_wr_t       wr,
  output dbgpio_pkg::out_item_t      res
);

  logic              fin;
  logic              fout;
  logic              is_input;
  logic              rd;
  dbgpio_pkg::err_t  err;
  dbgpio_pkg::word_t mask;
  dbgpio_pkg::word_t data_nxt;
  dbgpio_pkg::word_t dir_nxt;

  always_comb begin
    fin      = (loc.bank == '0) ? cfg.first_fixed_in : cfg.second_fixed_in;
    fout     = (loc.bank == '0) ? cfg.first_fixed_out : cfg.second_fixed_out;
    mask     = dbgpio_pkg::word_t'(1) << loc.pin;
    is_input = fin | (~fout & cur_dir[loc.pin]);
    rd       = 1'b0;
    err      = dbgpio_pkg::ERR_OK;
    data_nxt = cur_data;
    dir_nxt  = cur_dir;
    case (item.func)
      dbgpio_pkg::FUNC_SET_VALUE: begin
        data_nxt = item.pin_value ? (cur_data | mask) : (cur_data & ~mask);
      end
      dbgpio_pkg::FUNC_GET_VALUE: begin
        rd = is_input ? item.input_levels[loc.pin] : cur_data[loc.pin];
      end
      dbgpio_pkg::FUNC_GET_FUNC: begin
        rd = ~is_input;
      end
      dbgpio_pkg::FUNC_MAKE_OUT: begin
        if (fin) begin
          err = dbgpio_pkg::ERR_LOCK;
        end else begin
          if (!fout) begin
            dir_nxt = cur_dir & ~mask;
          end
          data_nxt = item.pin_value ? (cur_data | mask) : (cur_data & ~mask);
        end
      end
      dbgpio_pkg::FUNC_MAKE_IN: begin
        if (!fin) begin
          if (fout) begin
            err = dbgpio_pkg::ERR_LOCK;
          end else begin
            dir_nxt = cur_dir | mask;
          end
        end
      end
      default: begin
      end
    endcase

    wr.en   = loc.valid;
    wr.bank = loc.bank;
    wr.data = data_nxt;
    wr.dir  = dir_nxt;

    if (loc.valid) begin
      res.read_bit      = rd;
      res.error_code    = err;
      res.bank_data_out = dbgpio_pkg::FIELD_W'(data_nxt);
      res.bank_dir_out  = dbgpio_pkg::FIELD_W'(dir_nxt);
    end else begin
      res.read_bit      = 1'b0;
      res.error_code    = dbgpio_pkg::ERR_PIN;
      res.bank_data_out = '0;
      res.bank_dir_out  = '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/dual_bank_gpio_pin_control.sv -----
// Top level of the dual-bank GPIO pin controller: channel registers and configuration.
//
//   Channel | Ports                                   | Direction
//   input   | in_valid, in_stall, in_data             | request transactions in
//   result  | out_valid, out_stall, out_data          | one result transaction per request
//   config  | cfg_wr_en, cfg_index, cfg_wdata         | register writes in
//
// A request is accepted into the input register and executed from there; its result is loaded
// into the output register when that register is empty or its stall is low.
// One request per cycle is sustained while out_stall is low; bank words update as results load.
// Reset clears the bank data words, sets every pin to input and restores the register defaults.
// A stalled result holds the output register, and the input register stalls only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module dual_bank_gpio_pin_control (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire dbgpio_pkg::in_item_t               in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output dbgpio_pkg::out_item_t                   out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dbgpio_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dbgpio_pkg::WIDTH_W-1:0]     cfg_wdata
);

  dbgpio_pkg::cfg_t      cfg_r;
  logic                  in_valid_r;
  dbgpio_pkg::in_item_t  in_item_r;
  logic                  out_valid_r;
  dbgpio_pkg::out_item_t out_item_r;

  logic                  advance;
  dbgpio_pkg::pin_loc_t  loc;
  dbgpio_pkg::word_t     cur_data;
  dbgpio_pkg::word_t     cur_dir;
  dbgpio_pkg::bank_wr_t  op_wr;
  dbgpio_pkg::bank_wr_t  bank_wr;
  dbgpio_pkg::out_item_t res;

  assign advance   = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = in_valid_r & out_valid_r & out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_comb begin
    bank_wr    = op_wr;
    bank_wr.en = op_wr.en & advance;
  end

  dbgpio_pin_decode u_decode (
    .flat (in_item_r.pin_offset),
    .cfg  (cfg_r),
    .loc  (loc)
  );

  dbgpio_bank_file u_banks (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_bank (loc.bank),
    .rd_data (cur_data),
    .rd_dir  (cur_dir),
    .wr      (bank_wr)
  );

  dbgpio_pin_op u_op (
    .item     (in_item_r),
    .loc      (loc),
    .cfg      (cfg_r),
    .cur_data (cur_data),
    .cur_dir  (cur_dir),
    .wr       (op_wr),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_width      <= dbgpio_pkg::WIDTH_W'(32);
      cfg_r.second_width     <= '0;
      cfg_r.first_fixed_in   <= 1'b0;
      cfg_r.first_fixed_out  <= 1'b0;
      cfg_r.second_fixed_in  <= 1'b0;
      cfg_r.second_fixed_out <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dbgpio_pkg::CFG_FIRST_WIDTH:      cfg_r.first_width      <= cfg_wdata;
        dbgpio_pkg::CFG_SECOND_WIDTH:     cfg_r.second_width     <= cfg_wdata;
        dbgpio_pkg::CFG_FIRST_FIXED_IN:   cfg_r.first_fixed_in   <= cfg_wdata[0];
        dbgpio_pkg::CFG_FIRST_FIXED_OUT:  cfg_r.first_fixed_out  <= cfg_wdata[0];
        dbgpio_pkg::CFG_SECOND_FIXED_IN:  cfg_r.second_fixed_in  <= cfg_wdata[0];
        dbgpio_pkg::CFG_SECOND_FIXED_OUT: cfg_r.second_fixed_out <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

endmodule
`default_nettype wire
